>>> rtl/uer_pkg.sv
// Shared constants, codes and types of the ultrasonic echo ranger.
// Used by the channel interfaces and the ranger top level; depends on nothing.
package uer_pkg;

  localparam int COUNT_BITS      = 17;
  localparam int TRIG_LOW_TICKS  = 2;
  localparam int TRIG_HIGH_TICKS = 10;
  localparam int SCALE_W         = 16;
  localparam int DIST_W          = 11;
  localparam int DIST_SHIFT      = 17;
  localparam int PROD_W          = COUNT_BITS + SCALE_W;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [SCALE_W-1:0]    scale_t;
  typedef logic [DIST_W-1:0]     dist_t;
  typedef logic [2:0]            phase_t;
  typedef logic [1:0]            status_t;
  typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  localparam count_t COUNT_MAX = '1;
  localparam count_t COUNT_LIM = COUNT_MAX - count_t'(1);
  localparam dist_t  DIST_MAX  = '1;

  localparam phase_t PH_IDLE       = 3'd0;
  localparam phase_t PH_TRIG_LOW   = 3'd1;
  localparam phase_t PH_TRIG_HIGH  = 3'd2;
  localparam phase_t PH_CHECK      = 3'd3;
  localparam phase_t PH_WAIT_START = 3'd4;
  localparam phase_t PH_WAIT_END   = 3'd5;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_BUSY     = 2'd1;
  localparam status_t ST_NO_START = 2'd2;
  localparam status_t ST_TOO_LONG = 2'd3;

  localparam cfg_addr_t REG_MAX_ECHO   = 3'd0;
  localparam cfg_addr_t REG_START_WAIT = 3'd1;
  localparam cfg_addr_t REG_OVERHEAD   = 3'd2;
  localparam cfg_addr_t REG_CM_SCALE   = 3'd3;
  localparam cfg_addr_t REG_INCH_SCALE = 3'd4;

  localparam logic [15:0] RST_MAX_ECHO   = 16'd29155;
  localparam logic [15:0] RST_START_WAIT = 16'd5800;
  localparam logic [7:0]  RST_OVERHEAD   = 8'd5;
  localparam scale_t      RST_CM_SCALE   = 16'd2248;
  localparam scale_t      RST_INCH_SCALE = 16'd885;

  typedef struct packed {
    logic    trig;
    logic    done;
    status_t status;
    count_t  width;
    scale_t  scale;
  } meas_t;

endpackage

>>> rtl/uer_ifs.sv
// Valid/ready channel interfaces for the ranger's input and result beats.
// Depends on uer_pkg for the field types.
interface uer_in_if;
  logic valid;
  logic ready;
  logic action;
  logic echo_level;
  logic use_inches;

  modport source (output valid, output action, output echo_level, output use_inches,
                  input ready);
  modport sink   (input valid, input action, input echo_level, input use_inches,
                  output ready);
endinterface

interface uer_out_if;
  logic                 valid;
  logic                 ready;
  logic                 trigger_level;
  logic                 done_res;
  uer_pkg::status_t     status;
  uer_pkg::dist_t       distance;

  modport source (output valid, output trigger_level, output done_res, output status,
                  output distance, input ready);
  modport sink   (input valid, input trigger_level, input done_res, input status,
                  input distance, output ready);
endinterface

>>> rtl/ultrasonic_echo_ranger_unit.sv
// Ultrasonic ping-echo ranger: trigger sequencing, echo timing and distance scaling.
// Depends on uer_pkg and the channel interfaces in uer_ifs.sv.
// Two register stages: an accepted input beat is registered in s1_r, then in the output
// registers, from which its result beat is offered on out_ch.
// Throughput: one beat per cycle unless out_ch stalls; the phase/counter update and the
// scale multiply sit in separate register stages.
// Reset (rst_n, synchronous): phase idle, counter and unit cleared, registers at defaults.
module ultrasonic_echo_ranger_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  uer_in_if.sink               in_ch,
  uer_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  uer_pkg::cfg_addr_t   cfg_addr,
  input  uer_pkg::cfg_data_t   cfg_wdata
);

  logic [15:0]     max_echo_r;
  logic [15:0]     start_wait_r;
  logic [7:0]      overhead_r;
  uer_pkg::scale_t cm_scale_r;
  uer_pkg::scale_t inch_scale_r;

  uer_pkg::phase_t phase_r, phase_nxt, phase_cur;
  uer_pkg::count_t count_r, count_nxt, count_inc, width_raw;
  logic            unit_r, unit_nxt;

  logic            s1_valid_r;
  uer_pkg::meas_t  s1_r, s1_nxt;

  logic            out_valid_r;
  logic            trig_r, done_r;
  uer_pkg::status_t status_r;
  uer_pkg::dist_t  dist_r, dist_nxt;

  logic [31:0]     start_lim, echo_lim, sum_wide;
  logic [uer_pkg::PROD_W-1:0] prod;
  logic [uer_pkg::PROD_W-1:0] dist_wide;

  logic out_adv, s1_adv, in_acc;

  assign out_adv     = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || out_adv;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign s1_adv      = out_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_echo_r   <= uer_pkg::RST_MAX_ECHO;
      start_wait_r <= uer_pkg::RST_START_WAIT;
      overhead_r   <= uer_pkg::RST_OVERHEAD;
      cm_scale_r   <= uer_pkg::RST_CM_SCALE;
      inch_scale_r <= uer_pkg::RST_INCH_SCALE;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        uer_pkg::REG_MAX_ECHO:   max_echo_r   <= cfg_wdata[15:0];
        uer_pkg::REG_START_WAIT: start_wait_r <= cfg_wdata[15:0];
        uer_pkg::REG_OVERHEAD:   overhead_r   <= cfg_wdata[7:0];
        uer_pkg::REG_CM_SCALE:   cm_scale_r   <= cfg_wdata[15:0];
        uer_pkg::REG_INCH_SCALE: inch_scale_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    sum_wide  = 32'(max_echo_r) + 32'(start_wait_r);
    start_lim = (sum_wide > 32'(uer_pkg::COUNT_LIM)) ? 32'(uer_pkg::COUNT_LIM) : sum_wide;
    echo_lim  = (32'(max_echo_r) > 32'(uer_pkg::COUNT_LIM)) ?
                32'(uer_pkg::COUNT_LIM) : 32'(max_echo_r);
  end

  always_comb begin
    phase_cur = (phase_r > uer_pkg::PH_WAIT_END) ? uer_pkg::PH_IDLE : phase_r;
    count_inc = (count_r == uer_pkg::COUNT_MAX) ? uer_pkg::COUNT_MAX
                                                : count_r + uer_pkg::count_t'(1);
    width_raw = (count_inc > uer_pkg::count_t'(overhead_r)) ?
                count_inc - uer_pkg::count_t'(overhead_r) : '0;

    phase_nxt     = phase_cur;
    count_nxt     = count_r;
    unit_nxt      = unit_r;
    s1_nxt.trig   = 1'b0;
    s1_nxt.done   = 1'b0;
    s1_nxt.status = uer_pkg::ST_OK;
    s1_nxt.width  = '0;
    s1_nxt.scale  = unit_r ? inch_scale_r : cm_scale_r;

    if (in_ch.action) begin
      if (phase_cur == uer_pkg::PH_IDLE) begin
        unit_nxt  = in_ch.use_inches;
        count_nxt = '0;
        phase_nxt = uer_pkg::PH_TRIG_LOW;
      end else if (phase_cur == uer_pkg::PH_TRIG_HIGH) begin
        s1_nxt.trig = 1'b1;
      end
    end else begin
      unique case (phase_cur)
        uer_pkg::PH_TRIG_LOW: begin
          count_nxt = count_inc;
          if (32'(count_inc) >= 32'(uer_pkg::TRIG_LOW_TICKS)) begin
            count_nxt = '0;
            phase_nxt = uer_pkg::PH_TRIG_HIGH;
          end
        end
        uer_pkg::PH_TRIG_HIGH: begin
          s1_nxt.trig = 1'b1;
          count_nxt   = count_inc;
          if (32'(count_inc) >= 32'(uer_pkg::TRIG_HIGH_TICKS)) begin
            count_nxt = '0;
            phase_nxt = uer_pkg::PH_CHECK;
          end
        end
        uer_pkg::PH_CHECK: begin
          count_nxt = '0;
          if (in_ch.echo_level) begin
            s1_nxt.done   = 1'b1;
            s1_nxt.status = uer_pkg::ST_BUSY;
            phase_nxt     = uer_pkg::PH_IDLE;
          end else begin
            phase_nxt = uer_pkg::PH_WAIT_START;
          end
        end
        uer_pkg::PH_WAIT_START: begin
          if (in_ch.echo_level) begin
            count_nxt = '0;
            phase_nxt = uer_pkg::PH_WAIT_END;
          end else begin
            count_nxt = count_inc;
            if (32'(count_inc) > start_lim) begin
              s1_nxt.done   = 1'b1;
              s1_nxt.status = uer_pkg::ST_NO_START;
              count_nxt     = '0;
              phase_nxt     = uer_pkg::PH_IDLE;
            end
          end
        end
        uer_pkg::PH_WAIT_END: begin
          count_nxt = count_inc;
          if (!in_ch.echo_level) begin
            s1_nxt.done  = 1'b1;
            s1_nxt.width = width_raw;
            count_nxt    = '0;
            phase_nxt    = uer_pkg::PH_IDLE;
          end else if (32'(count_inc) > echo_lim) begin
            s1_nxt.done   = 1'b1;
            s1_nxt.status = uer_pkg::ST_TOO_LONG;
            count_nxt     = '0;
            phase_nxt     = uer_pkg::PH_IDLE;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= uer_pkg::PH_IDLE;
      count_r    <= '0;
      unit_r     <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_r <= phase_nxt;
        count_r <= count_nxt;
        unit_r  <= unit_nxt;
      end
      if (in_ch.ready) begin
        s1_valid_r <= in_acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= s1_nxt;
    end
  end

  always_comb begin
    prod      = uer_pkg::PROD_W'(s1_r.width) * uer_pkg::PROD_W'(s1_r.scale);
    dist_wide = prod >> uer_pkg::DIST_SHIFT;
    dist_nxt  = (dist_wide > uer_pkg::PROD_W'(uer_pkg::DIST_MAX)) ?
                uer_pkg::DIST_MAX : dist_wide[uer_pkg::DIST_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      trig_r   <= s1_r.trig;
      done_r   <= s1_r.done;
      status_r <= s1_r.status;
      dist_r   <= dist_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.trigger_level = trig_r;
  assign out_ch.done_res      = done_r;
  assign out_ch.status        = status_r;
  assign out_ch.distance      = dist_r;

endmodule

>>> sim/tb_ultrasonic_echo_ranger_unit.sv
// Self-checking testbench for the ultrasonic echo ranger: directed and random pings
// across several register settings, each result beat compared with a local prediction.
// Depends on uer_pkg, the channel interfaces in uer_ifs.sv and the ranger top level.
`timescale 1ns / 1ps

module tb_ultrasonic_echo_ranger_unit;

  localparam logic ACT_TICK  = 1'b0;
  localparam logic ACT_START = 1'b1;

  typedef struct packed {
    logic action;
    logic echo_level;
    logic use_inches;
  } ping_item_t;

  typedef struct packed {
    logic             trig;
    logic             done;
    uer_pkg::status_t status;
    uer_pkg::dist_t   distance;
  } reading_t;

  typedef struct packed {
    uer_pkg::phase_t phase;
    uer_pkg::count_t count;
    logic            inches;
  } ranger_state_t;

  typedef struct packed {
    logic [15:0]     max_echo;
    logic [15:0]     start_wait;
    logic [7:0]      overhead;
    uer_pkg::scale_t cm;
    uer_pkg::scale_t inch;
  } ranger_cfg_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_action = 1'b0;
  logic in_echo = 1'b0;
  logic in_inches = 1'b0;
  logic out_ready = 1'b0;
  logic cfg_we = 1'b0;
  uer_pkg::cfg_addr_t cfg_addr = '0;
  uer_pkg::cfg_data_t cfg_wdata = '0;

  uer_in_if in_if();
  uer_out_if out_if();

  assign in_if.valid      = in_valid;
  assign in_if.action     = in_action;
  assign in_if.echo_level = in_echo;
  assign in_if.use_inches = in_inches;
  assign out_if.ready     = out_ready;

  ultrasonic_echo_ranger_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_if),
    .out_ch   (out_if),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  ranger_cfg_t   cfg = '{uer_pkg::RST_MAX_ECHO, uer_pkg::RST_START_WAIT,
                         uer_pkg::RST_OVERHEAD, uer_pkg::RST_CM_SCALE,
                         uer_pkg::RST_INCH_SCALE};
  ranger_state_t gen_st = '{uer_pkg::PH_IDLE, '0, 1'b0};
  ranger_state_t model_st = '{uer_pkg::PH_IDLE, '0, 1'b0};

  ping_item_t ping_items[$];
  reading_t   expected_readings[$];
  ping_item_t cur_item = '0;

  int items_queued = 0;
  int items_accepted = 0;
  int results_checked = 0;
  int errors = 0;
  int settings_used = 1;
  int n_ok = 0, n_busy = 0, n_no_start = 0, n_too_long = 0;

  function automatic uer_pkg::count_t sat_inc(uer_pkg::count_t c);
    return (c >= uer_pkg::COUNT_MAX) ? uer_pkg::COUNT_MAX : c + uer_pkg::count_t'(1);
  endfunction

  function automatic longint unsigned clamp_lim(longint unsigned lim);
    return (lim > longint'(uer_pkg::COUNT_LIM)) ? longint'(uer_pkg::COUNT_LIM) : lim;
  endfunction

  function automatic void range_step(input ranger_state_t s, input ranger_cfg_t c,
                                     input ping_item_t it, output ranger_state_t n,
                                     output reading_t r);
    longint unsigned w;
    longint unsigned prod;
    uer_pkg::scale_t sc;
    n = s;
    r = '0;
    if (n.phase > uer_pkg::PH_WAIT_END) n.phase = uer_pkg::PH_IDLE;
    if (it.action == ACT_START) begin
      if (n.phase == uer_pkg::PH_IDLE) begin
        n.inches = it.use_inches;
        n.count  = '0;
        n.phase  = uer_pkg::PH_TRIG_LOW;
      end else if (n.phase == uer_pkg::PH_TRIG_HIGH) begin
        r.trig = 1'b1;
      end
    end else begin
      case (n.phase)
        uer_pkg::PH_TRIG_LOW: begin
          n.count = sat_inc(n.count);
          if (n.count >= uer_pkg::count_t'(uer_pkg::TRIG_LOW_TICKS)) begin
            n.count = '0;
            n.phase = uer_pkg::PH_TRIG_HIGH;
          end
        end
        uer_pkg::PH_TRIG_HIGH: begin
          r.trig  = 1'b1;
          n.count = sat_inc(n.count);
          if (n.count >= uer_pkg::count_t'(uer_pkg::TRIG_HIGH_TICKS)) begin
            n.count = '0;
            n.phase = uer_pkg::PH_CHECK;
          end
        end
        uer_pkg::PH_CHECK: begin
          if (it.echo_level) begin
            r.done   = 1'b1;
            r.status = uer_pkg::ST_BUSY;
            n.phase  = uer_pkg::PH_IDLE;
          end else begin
            n.phase = uer_pkg::PH_WAIT_START;
          end
          n.count = '0;
        end
        uer_pkg::PH_WAIT_START: begin
          if (it.echo_level) begin
            n.count = '0;
            n.phase = uer_pkg::PH_WAIT_END;
          end else begin
            n.count = sat_inc(n.count);
            if (longint'(n.count) > clamp_lim(longint'(c.max_echo) + longint'(c.start_wait)))
            begin
              r.done   = 1'b1;
              r.status = uer_pkg::ST_NO_START;
              n.count  = '0;
              n.phase  = uer_pkg::PH_IDLE;
            end
          end
        end
        uer_pkg::PH_WAIT_END: begin
          n.count = sat_inc(n.count);
          if (!it.echo_level) begin
            w    = (n.count > c.overhead) ? longint'(n.count) - longint'(c.overhead) : 0;
            sc   = n.inches ? c.inch : c.cm;
            prod = (w * longint'(sc)) >> uer_pkg::DIST_SHIFT;
            r.distance = (prod > longint'(uer_pkg::DIST_MAX)) ?
                         uer_pkg::DIST_MAX : uer_pkg::dist_t'(prod);
            r.done  = 1'b1;
            n.count = '0;
            n.phase = uer_pkg::PH_IDLE;
          end else if (longint'(n.count) > clamp_lim(longint'(c.max_echo))) begin
            r.done   = 1'b1;
            r.status = uer_pkg::ST_TOO_LONG;
            n.count  = '0;
            n.phase  = uer_pkg::PH_IDLE;
          end
        end
        default: ;
      endcase
    end
  endfunction

  function automatic int next_gap(bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH at result %0d: %s got %0d expected %0d", results_checked, what, got, want);
    errors++;
  endtask

  int  in_gap = 0;
  int  in_beats = 0;
  bit  in_quiet = 1'b0;

  always @(posedge clk) begin
    reading_t r;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_if.ready) begin
        range_step(model_st, cfg, cur_item, model_st, r);
        expected_readings.push_back(r);
        items_accepted++;
      end
      if (!in_valid || in_if.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (ping_items.size() > 0) begin
          cur_item = ping_items.pop_front();
          in_action <= cur_item.action;
          in_echo   <= cur_item.echo_level;
          in_inches <= cur_item.use_inches;
          in_valid  <= 1'b1;
          in_beats++;
          if (in_beats % 150 == 0) in_quiet = ($urandom_range(0, 9) < 3);
          in_gap = next_gap(in_quiet);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  int  out_stall = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  bit  out_quiet = 1'b0;

  always @(posedge clk) begin
    reading_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_if.valid && out_ready) begin
        if (expected_readings.size() == 0) begin
          report_mismatch("unexpected result beat", 1, 0);
        end else begin
          e = expected_readings.pop_front();
          if (out_if.trigger_level !== e.trig)
            report_mismatch("trigger_level", out_if.trigger_level, e.trig);
          if (out_if.done_res !== e.done) report_mismatch("done_res", out_if.done_res, e.done);
          if (out_if.status !== e.status) report_mismatch("status", out_if.status, e.status);
          if (out_if.distance !== e.distance)
            report_mismatch("distance", out_if.distance, e.distance);
          if (e.done) begin
            case (e.status)
              uer_pkg::ST_OK:       n_ok++;
              uer_pkg::ST_BUSY:     n_busy++;
              uer_pkg::ST_NO_START: n_no_start++;
              default:              n_too_long++;
            endcase
          end
        end
        results_checked++;
        if (results_checked % 150 == 0) out_quiet = ($urandom_range(0, 9) < 3);
      end
      if (!hold_done && ping_items.size() > 200) begin
        hold_left = 300;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (out_stall > 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        out_stall = next_gap(out_quiet);
      end
    end
  end

  task automatic push_item(logic action, logic echo, logic inches);
    ping_item_t it;
    reading_t   r;
    it = '{action, echo, inches};
    range_step(gen_st, cfg, it, gen_st, r);
    ping_items.push_back(it);
    items_queued++;
  endtask

  task automatic maybe_noise(bit noisy);
    if (noisy && $urandom_range(0, 99) < 8)
      push_item(logic'($urandom_range(0, 1)), logic'($urandom_range(0, 1)),
                logic'($urandom_range(0, 1)));
  endtask

  task automatic finish_ping();
    while (gen_st.phase != uer_pkg::PH_IDLE)
      push_item(ACT_TICK, gen_st.phase == uer_pkg::PH_WAIT_START,
                logic'($urandom_range(0, 1)));
  endtask

  task automatic add_ping(bit inches, bit busy, int pre, int pulse, bit noisy);
    push_item(ACT_START, logic'($urandom_range(0, 1)), inches);
    while (gen_st.phase == uer_pkg::PH_TRIG_LOW || gen_st.phase == uer_pkg::PH_TRIG_HIGH) begin
      maybe_noise(noisy);
      push_item(ACT_TICK, logic'($urandom_range(0, 1)), logic'($urandom_range(0, 1)));
    end
    if (gen_st.phase == uer_pkg::PH_CHECK)
      push_item(ACT_TICK, busy, logic'($urandom_range(0, 1)));
    for (int i = 0; i < pre && gen_st.phase == uer_pkg::PH_WAIT_START; i++) begin
      maybe_noise(noisy);
      push_item(ACT_TICK, 1'b0, logic'($urandom_range(0, 1)));
    end
    for (int i = 0; i < pulse; i++) begin
      if (gen_st.phase != uer_pkg::PH_WAIT_START && gen_st.phase != uer_pkg::PH_WAIT_END)
        break;
      maybe_noise(noisy);
      push_item(ACT_TICK, 1'b1, logic'($urandom_range(0, 1)));
    end
    finish_ping();
  endtask

  task automatic wait_drained();
    while (items_accepted != items_queued || expected_readings.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_reg(uer_pkg::cfg_addr_t a, uer_pkg::cfg_data_t d);
    cfg_we    <= 1'b1;
    cfg_addr  <= a;
    cfg_wdata <= d;
    @(posedge clk);
  endtask

  task automatic apply_cfg(ranger_cfg_t c);
    wait_drained();
    repeat (4) @(posedge clk);
    write_reg(uer_pkg::REG_MAX_ECHO, c.max_echo);
    write_reg(uer_pkg::REG_START_WAIT, c.start_wait);
    write_reg(uer_pkg::REG_OVERHEAD, uer_pkg::cfg_data_t'(c.overhead));
    write_reg(uer_pkg::REG_CM_SCALE, c.cm);
    write_reg(uer_pkg::REG_INCH_SCALE, c.inch);
    cfg_we <= 1'b0;
    @(posedge clk);
    cfg = c;
    settings_used++;
  endtask

  function automatic logic [15:0] pick_word(int hi);
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 16'd0;
    if (r < 20) return 16'hFFFF;
    return 16'($urandom_range(0, hi));
  endfunction

  task automatic random_ping();
    int lim;
    int pre;
    int pulse;
    int r;
    lim = int'(cfg.max_echo) + int'(cfg.start_wait);
    r = $urandom_range(0, 99);
    if (r < 60) pre = $urandom_range(0, 20);
    else if (r < 80 && lim <= 700) pre = $urandom_range(lim, lim + 1);
    else pre = $urandom_range(0, 100);
    r = $urandom_range(0, 99);
    if (r < 50) pulse = $urandom_range(1, 40);
    else if (r < 70 && cfg.max_echo <= 600)
      pulse = $urandom_range(int'(cfg.max_echo), int'(cfg.max_echo) + 2);
    else if (r < 85) pulse = $urandom_range(int'(cfg.overhead), int'(cfg.overhead) + 2);
    else pulse = $urandom_range(1, 600);
    if (pulse < 1) pulse = 1;
    add_ping(logic'($urandom_range(0, 1)), $urandom_range(0, 9) == 0, pre, pulse,
             $urandom_range(0, 3) != 0);
  endtask

  initial begin
    ranger_cfg_t c;
    int target;
    int phase_start;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    push_item(ACT_TICK, 1'b0, 1'b0);
    push_item(ACT_TICK, 1'b1, 1'b1);
    push_item(ACT_START, 1'b1, 1'b0);
    repeat (4) push_item(ACT_TICK, 1'b0, 1'b0);
    push_item(ACT_START, 1'b0, 1'b1);
    finish_ping();
    add_ping(1'b0, 1'b1, 0, 0, 1'b0);
    add_ping(1'b0, 1'b0, 3, 200, 1'b0);
    add_ping(1'b1, 1'b0, 0, 300, 1'b0);
    add_ping(1'b0, 1'b0, 1, 5, 1'b0);

    apply_cfg('{16'd20, 16'd5, 8'd0, 16'hFFFF, 16'd0});
    add_ping(1'b0, 1'b0, 26, 0, 1'b0);
    add_ping(1'b0, 1'b0, 2, 22, 1'b0);
    add_ping(1'b0, 1'b0, 25, 21, 1'b0);
    add_ping(1'b1, 1'b0, 0, 10, 1'b0);

    apply_cfg('{16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF});
    add_ping(1'b0, 1'b0, 2, 4400, 1'b0);
    add_ping(1'b1, 1'b0, 0, 300, 1'b0);

    apply_cfg('{16'd0, 16'd0, 8'd0, 16'd0, 16'd0});
    add_ping(1'b0, 1'b0, 1, 0, 1'b0);
    add_ping(1'b0, 1'b0, 0, 2, 1'b0);
    add_ping(1'b1, 1'b0, 0, 1, 1'b0);

    target = items_queued + 1800;
    while (items_queued < target) begin
      c.max_echo   = pick_word(400);
      c.start_wait = pick_word(200);
      c.overhead   = 8'(pick_word(255));
      c.cm         = pick_word(65535);
      c.inch       = pick_word(65535);
      apply_cfg(c);
      phase_start = items_queued;
      while (items_queued - phase_start < 250 && items_queued < target) random_ping();
    end

    wait_drained();
    repeat (8) @(posedge clk);
    $display("Covered %0d input beats and %0d result beats over %0d register settings.",
             items_accepted, results_checked, settings_used);
    $display("Finished pings: %0d ok, %0d busy, %0d echo never started, %0d echo too long.",
             n_ok, n_busy, n_no_start, n_too_long);
    if (errors == 0) begin
      $display("ultrasonic_echo_ranger_unit regression: pass");
    end else begin
      $display("ultrasonic_echo_ranger_unit regression: fail");
    end
    $finish;
  end

  initial begin
    #50000000;
    $display("Timed out with %0d results still expected.", expected_readings.size());
    $display("ultrasonic_echo_ranger_unit regression: fail");
    $finish;
  end

endmodule
